[sv/sfg_pkg.sv]
// shared constants, types and helpers for the falling-sand grid engine
package sfg_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int WORD_W    = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CNT_W     = ROW_W + 1;
  localparam int SIZE_W    = 7;
  localparam int SEED_W    = 16;
  localparam int POS_W     = 6;
  localparam int STEP_COLS = 8;
  localparam int CHUNKS    = WORD_W / STEP_COLS;
  localparam int CHUNK_W   = $clog2(CHUNKS);

  localparam logic [SEED_W-1:0] SEED_DEFAULT = 16'hACE1;
  localparam logic [SEED_W-1:0] LFSR_TAPS    = 16'hB400;

  localparam logic [1:0] CFG_IDX_ROWS = 2'd0;
  localparam logic [1:0] CFG_IDX_COLS = 2'd1;
  localparam logic [1:0] CFG_IDX_SEED = 2'd2;

  typedef enum logic [1:0] {
    MODE_PLACE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_GEN   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLACE,
    ST_READ,
    ST_G_LDDN,
    ST_G_LDUP,
    ST_G_PROC,
    ST_G_WB,
    ST_G_LAST,
    ST_TRIM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [ROW_W-1:0]  rd_addr;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              clr_all;
  } grid_req_t;

  // register value limited to the physical size
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v, input int lim);
    logic [SIZE_W-1:0] res;
    res = v;
    if (int'(v) > lim) begin
      res = SIZE_W'(lim);
    end
    return res;
  endfunction

endpackage

[sv/sfg_grid_mem.sv]
// grid row memory with per-row valid bits and a registered read port
module sfg_grid_mem
  import sfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  grid_req_t         req,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0]   mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] valid_r;
  logic [WORD_W-1:0]   rd_q_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r   <= mem[req.rd_addr];
      rd_vld_r <= valid_r[req.rd_addr];
    end
  end

  // a row never written since reset or clear reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n || req.clr_all) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[sv/sfg_gen_step.sv]
// one chunk of columns of a generation on the current row pair
module sfg_gen_step
  import sfg_pkg::*;
(
  input  logic [WORD_W-1:0]  up_i,
  input  logic [WORD_W-1:0]  dn_i,
  input  logic [SEED_W-1:0]  lfsr_i,
  input  logic [CHUNK_W-1:0] chunk_i,
  input  logic [SIZE_W-1:0]  ncols_i,
  output logic [WORD_W-1:0]  up_o,
  output logic [WORD_W-1:0]  dn_o,
  output logic [SEED_W-1:0]  lfsr_o
);

  logic [WORD_W-1:0] u;
  logic [WORD_W-1:0] d;
  logic [SEED_W-1:0] l;
  logic [SIZE_W-1:0] x;
  logic              lf;
  logic              rf;
  logic              pick;

  // the row words are rotated so that the current chunk sits in the low bits
  always_comb begin
    u    = up_i;
    d    = dn_i;
    l    = lfsr_i;
    x    = '0;
    lf   = 1'b0;
    rf   = 1'b0;
    pick = 1'b0;
    for (int k = 0; k < STEP_COLS; k++) begin
      x  = SIZE_W'({chunk_i, CHUNK_W'(0)}) + SIZE_W'(k);
      lf = 1'b0;
      rf = 1'b0;
      if (x < ncols_i && u[k]) begin
        if (!d[k]) begin
          d[k] = 1'b1;
          u[k] = 1'b0;
        end else begin
          lf = (x != '0) && !d[(k + WORD_W - 1) % WORD_W];
          rf = ((x + SIZE_W'(1)) < ncols_i) && !d[k + 1];
          if (lf && rf) begin
            pick = l[0];
            l    = l >> 1;
            if (pick) begin
              l  = l ^ LFSR_TAPS;
              lf = 1'b0;
            end else begin
              rf = 1'b0;
            end
          end
          if (lf) begin
            d[(k + WORD_W - 1) % WORD_W] = 1'b1;
            u[k] = 1'b0;
          end else if (rf) begin
            d[k + 1] = 1'b1;
            u[k] = 1'b0;
          end
        end
      end
    end
    up_o   = {u[STEP_COLS-1:0], u[WORD_W-1:STEP_COLS]};
    dn_o   = {d[STEP_COLS-1:0], d[WORD_W-1:STEP_COLS]};
    lfsr_o = l;
  end

endmodule

[sv/falling_sand_grid_step.sv]
// falling-sand grid engine: command sequencer around the grid row memory
//
// Input channel (in_valid/in_stall) takes one command per transfer: place a
// grain, clear the grid, run one generation or read a cell. Every command
// gives exactly one result on the output channel (out_valid/out_stall):
// the read cell value (0 for other commands) and the echoed mode.
// Commands are handled one at a time. A generation reads each active row
// once and rewrites it after the column unit, which updates eight columns
// per cycle, has swept every chunk of the row pair.
// A finished result waits in the output register, and the next command is
// taken meanwhile; a command that ends while that register is still full
// waits until the receiver takes the old result.
// Configuration writes (cfg_valid/cfg_ready) are taken only when no command
// is in work. A write to the row or column count starts a trim sweep of
// all MAX_ROWS rows of the memory, with in_stall and cfg_ready held off.
// Reset gives an empty grid, a 64 by 64 active area and the default seed.
module falling_sand_grid_step
  import sfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [POS_W-1:0]  in_row,
  input  logic [POS_W-1:0]  in_col,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_cell_value,
  output logic [1:0]        out_done_mode,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [SEED_W-1:0] cfg_data
);

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [POS_W-1:0]   col_r, col_nxt;
  logic               cell_r, cell_nxt;
  logic [SIZE_W-1:0]  rows_r, rows_nxt;
  logic [SIZE_W-1:0]  cols_r, cols_nxt;
  logic [SEED_W-1:0]  lfsr_r, lfsr_nxt;
  logic [WORD_W-1:0]  up_r, up_nxt;
  logic [WORD_W-1:0]  dn_r, dn_nxt;
  logic [ROW_W-1:0]   gen_y_r, gen_y_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_cell_r, out_cell_nxt;
  mode_t              out_mode_r, out_mode_nxt;

  grid_req_t          req;
  logic [WORD_W-1:0]  rd_data;
  logic [WORD_W-1:0]  step_up;
  logic [WORD_W-1:0]  step_dn;
  logic [SEED_W-1:0]  step_lfsr;
  logic [SIZE_W-1:0]  eff_rows;
  logic [SIZE_W-1:0]  eff_cols;
  logic [WORD_W-1:0]  col_mask;
  logic               in_area;
  logic [ROW_W-1:0]   top_row;
  logic [CNT_W-1:0]   trim_row;

  sfg_grid_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

  sfg_gen_step u_step (
    .up_i    (up_r),
    .dn_i    (dn_r),
    .lfsr_i  (lfsr_r),
    .chunk_i (chunk_r),
    .ncols_i (eff_cols),
    .up_o    (step_up),
    .dn_o    (step_dn),
    .lfsr_o  (step_lfsr)
  );

  assign eff_rows = clamp_size(rows_r, MAX_ROWS);
  assign eff_cols = clamp_size(cols_r, MAX_COLS);
  assign col_mask = (eff_cols >= SIZE_W'(WORD_W)) ? '1 :
                    ((WORD_W'(1) << eff_cols) - WORD_W'(1));
  assign in_area  = (SIZE_W'(in_row) < eff_rows) && (SIZE_W'(in_col) < eff_cols);
  assign top_row  = ROW_W'(eff_rows - SIZE_W'(1));
  assign trim_row = cnt_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rows_r      <= SIZE_W'(64);
      cols_r      <= SIZE_W'(64);
      lfsr_r      <= SEED_DEFAULT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      lfsr_r      <= lfsr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    cell_r     <= cell_nxt;
    up_r       <= up_nxt;
    dn_r       <= dn_nxt;
    gen_y_r    <= gen_y_nxt;
    chunk_r    <= chunk_nxt;
    cnt_r      <= cnt_nxt;
    out_cell_r <= out_cell_nxt;
    out_mode_r <= out_mode_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    cell_nxt      = cell_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    lfsr_nxt      = lfsr_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    gen_y_nxt     = gen_y_r;
    chunk_nxt     = chunk_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_cell_nxt  = out_cell_r;
    out_mode_nxt  = out_mode_r;
    req           = '0;
    in_stall      = 1'b1;
    cfg_ready     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_stall  = cfg_valid;
        if (cfg_valid) begin
          case (cfg_index)
            CFG_IDX_ROWS: begin
              rows_nxt  = cfg_data[SIZE_W-1:0];
              cnt_nxt   = '0;
              state_nxt = ST_TRIM;
            end
            CFG_IDX_COLS: begin
              cols_nxt  = cfg_data[SIZE_W-1:0];
              cnt_nxt   = '0;
              state_nxt = ST_TRIM;
            end
            CFG_IDX_SEED: begin
              lfsr_nxt = (cfg_data == '0) ? SEED_DEFAULT : cfg_data;
            end
            default: begin
            end
          endcase
        end else if (in_valid) begin
          mode_nxt  = mode_t'(in_mode);
          row_nxt   = ROW_W'(in_row);
          col_nxt   = in_col;
          cell_nxt  = 1'b0;
          state_nxt = ST_DONE;
          case (mode_t'(in_mode))
            MODE_PLACE: begin
              if (in_area) begin
                req.rd_en   = 1'b1;
                req.rd_addr = ROW_W'(in_row);
                state_nxt   = ST_PLACE;
              end
            end
            MODE_CLEAR: begin
              req.clr_all = 1'b1;
            end
            MODE_GEN: begin
              if (eff_rows >= SIZE_W'(2) && eff_cols != '0) begin
                req.rd_en   = 1'b1;
                req.rd_addr = top_row;
                gen_y_nxt   = top_row;
                state_nxt   = ST_G_LDDN;
              end
            end
            MODE_READ: begin
              if (in_area) begin
                req.rd_en   = 1'b1;
                req.rd_addr = ROW_W'(in_row);
                state_nxt   = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PLACE: begin
        req.wr_en   = 1'b1;
        req.wr_addr = row_r;
        req.wr_data = rd_data | (WORD_W'(1) << col_r);
        state_nxt   = ST_DONE;
      end
      ST_READ: begin
        cell_nxt  = rd_data[col_r];
        state_nxt = ST_DONE;
      end
      ST_G_LDDN: begin
        dn_nxt      = rd_data;
        req.rd_en   = 1'b1;
        req.rd_addr = gen_y_r - ROW_W'(1);
        state_nxt   = ST_G_LDUP;
      end
      ST_G_LDUP: begin
        up_nxt    = rd_data;
        chunk_nxt = '0;
        state_nxt = ST_G_PROC;
      end
      ST_G_PROC: begin
        up_nxt    = step_up;
        dn_nxt    = step_dn;
        lfsr_nxt  = step_lfsr;
        chunk_nxt = chunk_r + CHUNK_W'(1);
        if (chunk_r == CHUNK_W'(CHUNKS - 1)) begin
          state_nxt = ST_G_WB;
        end
      end
      ST_G_WB: begin
        // lower row is final; the upper row becomes the next lower row
        req.wr_en   = 1'b1;
        req.wr_addr = gen_y_r;
        req.wr_data = dn_r;
        dn_nxt      = up_r;
        gen_y_nxt   = gen_y_r - ROW_W'(1);
        if (gen_y_r == ROW_W'(1)) begin
          state_nxt = ST_G_LAST;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = gen_y_r - ROW_W'(2);
          state_nxt   = ST_G_LDUP;
        end
      end
      ST_G_LAST: begin
        req.wr_en   = 1'b1;
        req.wr_addr = '0;
        req.wr_data = dn_r;
        state_nxt   = ST_DONE;
      end
      ST_TRIM: begin
        // read one row ahead while writing back the trimmed previous one
        if (cnt_r < CNT_W'(MAX_ROWS)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = cnt_r[ROW_W-1:0];
        end
        if (cnt_r != '0) begin
          req.wr_en   = 1'b1;
          req.wr_addr = trim_row[ROW_W-1:0];
          req.wr_data = (32'(trim_row) < 32'(eff_rows)) ? (rd_data & col_mask) : '0;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_ROWS)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = cell_r;
          out_mode_nxt  = mode_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_done_mode  = out_mode_r;

endmodule
